/* rtl/vmu_pkg.sv */
`default_nettype none
package vmu_pkg;
	localparam int VMU_FRAC_BITS = 16;

	typedef logic [31:0] word_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_DOT   = 4'd4,
		OP_LSQ   = 4'd5,
		OP_LEN   = 4'd6,
		OP_UNIT  = 4'd7,
		OP_CROSS = 4'd8
	} op_t;

	localparam word_t S32_MAX = 32'h7fff_ffff;
	localparam word_t S32_MIN = 32'h8000_0000;

	typedef struct packed {
		op_t         op;
		word_t [2:0] a;
		word_t [2:0] b;
		word_t [2:0] r;
		word_t       s;
		logic        ov;
		logic        dz;
	} item_t;

	typedef struct packed {
		logic [63:0] n;
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	typedef struct packed {
		word_t md;
		word_t rem;
		word_t nlo;
		word_t q;
		logic  neg;
		logic  dz;
		logic  big;
		logic  npos;
		logic  nneg;
	} div_t;

	// Saturates a wide signed value to 32 bits; the top bit reports saturation.
	function automatic logic [32:0] sat_word(input logic signed [66:0] v);
		logic [32:0] res;
		if (v > 67'sd2147483647) begin
			res = {1'b1, S32_MAX};
		end else if (v < -67'sd2147483648) begin
			res = {1'b1, S32_MIN};
		end else begin
			res = {1'b0, v[31:0]};
		end
		return res;
	endfunction
endpackage
`default_nettype wire

/* rtl/vmu_sqrt_stage.sv */
`default_nettype none
module vmu_sqrt_stage import vmu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  up_valid,
	input  item_t up_item,
	input  sqrt_t up_sq,
	output logic  dn_valid,
	output item_t dn_item,
	output sqrt_t dn_sq
);
	logic [35:0] rem_cat;
	logic [35:0] trial;
	logic        take;
	sqrt_t       nxt;
	logic        valid_s1;
	item_t       item_s1;
	sqrt_t       sq_s1;

	always_comb begin
		rem_cat  = {up_sq.rem, up_sq.n[63:62]};
		trial    = {2'b00, up_sq.root, 2'b01};
		take     = rem_cat >= trial;
		nxt.n    = {up_sq.n[61:0], 2'b00};
		nxt.rem  = take ? 34'(rem_cat - trial) : rem_cat[33:0];
		nxt.root = {up_sq.root[30:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= up_item;
			sq_s1   <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;
	assign dn_sq    = sq_s1;
endmodule
`default_nettype wire

/* rtl/vmu_div_stage.sv */
`default_nettype none
module vmu_div_stage import vmu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       up_valid,
	input  item_t      up_item,
	input  div_t [2:0] up_ln,
	output logic       dn_valid,
	output item_t      dn_item,
	output div_t [2:0] dn_ln
);
	logic [32:0] rem_cat [3];
	logic        take [3];
	div_t [2:0]  nxt;
	logic        valid_s1;
	item_t       item_s1;
	div_t [2:0]  ln_s1;

	always_comb begin
		nxt = up_ln;
		for (int i = 0; i < 3; i++) begin
			rem_cat[i]  = {up_ln[i].rem, up_ln[i].nlo[31]};
			take[i]     = rem_cat[i] >= {1'b0, up_ln[i].md};
			nxt[i].rem  = take[i] ? 32'(rem_cat[i] - {1'b0, up_ln[i].md}) : rem_cat[i][31:0];
			nxt[i].nlo  = {up_ln[i].nlo[30:0], 1'b0};
			nxt[i].q    = {up_ln[i].q[30:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= up_item;
			ln_s1   <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;
	assign dn_ln    = ln_s1;
endmodule
`default_nettype wire

/* rtl/vec3_math_unit_core.sv */
// Three-component fixed-point vector ALU.
// The request channel (req_valid, req_ready) carries an operation code and two
// signed vectors a and b; the response channel (rsp_valid, rsp_ready) returns
// one result item per request, in order: a vector r, a scalar, and the
// overflow and divide-by-zero flags.
// Every item takes the same path: registered stages of products, sums and
// rounding, a 32-stage square root that resolves one root bit per stage, a
// setup stage, a 32-stage divider that resolves one quotient bit per stage,
// and the output register.
// One item is accepted in every cycle while the response side takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
`default_nettype none
module vec3_math_unit_core import vmu_pkg::*; #(
	parameter int FRAC_BITS = VMU_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] scalar_out,
	output logic               overflow,
	output logic               div_zero
);
	localparam int NW = 33 + FRAC_BITS;
	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

	logic en;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7;
	item_t it2_d, it4_d, it5_d, it6_d, it7_d;

	logic signed [31:0] ma [3];
	logic signed [31:0] mb [3];
	logic signed [31:0] mc [3];
	logic signed [31:0] mdo [3];
	logic signed [32:0] as_sum [3];
	logic [32:0]        as_sat [3];
	logic               sq_op;

	logic signed [63:0] pa_s2 [3];
	logic signed [63:0] pc_s2 [3];
	logic signed [64:0] sl_s3 [3];
	logic signed [66:0] sc_s4;
	logic signed [66:0] rnd [3];
	logic [32:0]        rnd_sat [3];
	logic signed [66:0] srnd;
	logic [32:0]        srnd_sat;
	sqrt_t              sq_in;

	logic  sqrt_valid [33];
	item_t sqrt_item [33];
	sqrt_t sqrt_st [33];

	logic [31:0]        root;
	logic signed [32:0] dsig [3];
	word_t              mn [3];
	word_t              mdm [3];
	logic [NW-1:0]      nfull [3];
	logic [NW-33:0]     hi [3];
	div_t [2:0]         dv_d;
	div_t [2:0]         dv_s6;

	logic       div_valid [33];
	item_t      div_item [33];
	div_t [2:0] div_ln [33];

	assign en        = !v_s7 || rsp_ready;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= sqrt_valid[32];
			v_s7 <= div_valid[32];
		end
	end

	// Stage 2: operand selection, the six multipliers, add and subtract.
	always_comb begin
		it2_d = it_s1;
		sq_op = it_s1.op == OP_LSQ || it_s1.op == OP_LEN || it_s1.op == OP_UNIT;
		for (int i = 0; i < 3; i++) begin
			ma[i]  = it_s1.a[i];
			mb[i]  = sq_op ? it_s1.a[i] : it_s1.b[i];
			mc[i]  = '0;
			mdo[i] = '0;
			if (it_s1.op == OP_CROSS) begin
				ma[i]  = it_s1.a[(i == 2) ? 0 : i + 1];
				mb[i]  = it_s1.b[(i == 0) ? 2 : i - 1];
				mc[i]  = it_s1.a[(i == 0) ? 2 : i - 1];
				mdo[i] = it_s1.b[(i == 2) ? 0 : i + 1];
			end
			if (it_s1.op == OP_SUB) begin
				as_sum[i] = {it_s1.a[i][31], it_s1.a[i]} - {it_s1.b[i][31], it_s1.b[i]};
			end else begin
				as_sum[i] = {it_s1.a[i][31], it_s1.a[i]} + {it_s1.b[i][31], it_s1.b[i]};
			end
			as_sat[i] = sat_word(67'(as_sum[i]));
			if (it_s1.op == OP_ADD || it_s1.op == OP_SUB) begin
				it2_d.r[i] = as_sat[i][31:0];
				it2_d.ov   = it2_d.ov | as_sat[i][32];
			end
		end
	end

	// Stage 4: lane rounding for mul and cross.
	always_comb begin
		it4_d = it_s3;
		for (int i = 0; i < 3; i++) begin
			rnd[i]     = (67'(sl_s3[i]) + HALF) >>> FRAC_BITS;
			rnd_sat[i] = sat_word(rnd[i]);
			if (it_s3.op == OP_MUL || it_s3.op == OP_CROSS) begin
				it4_d.r[i] = rnd_sat[i][31:0];
				it4_d.ov   = it4_d.ov | rnd_sat[i][32];
			end
		end
	end

	// Stage 5: scalar rounding for dot and squared length.
	always_comb begin
		it5_d    = it_s4;
		srnd     = (sc_s4 + HALF) >>> FRAC_BITS;
		srnd_sat = sat_word(srnd);
		if (it_s4.op == OP_DOT || it_s4.op == OP_LSQ) begin
			it5_d.s  = srnd_sat[31:0];
			it5_d.ov = srnd_sat[32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.op <= op_t'(req_type);
			it_s1.a  <= {a_z, a_y, a_x};
			it_s1.b  <= {b_z, b_y, b_x};
			it_s1.r  <= '0;
			it_s1.s  <= '0;
			it_s1.ov <= 1'b0;
			it_s1.dz <= 1'b0;
			it_s2    <= it2_d;
			it_s3    <= it_s2;
			it_s4    <= it4_d;
			it_s5    <= it5_d;
			sc_s4    <= sl_s3[0] + sl_s3[1] + sl_s3[2];
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= ma[i] * mb[i];
				pc_s2[i] <= mc[i] * mdo[i];
				sl_s3[i] <= pa_s2[i] - pc_s2[i];
			end
			sq_in.n    <= sc_s4[63:0];
			sq_in.rem  <= '0;
			sq_in.root <= '0;
		end
	end

	assign sqrt_valid[0] = v_s5;
	assign sqrt_item[0]  = it_s5;
	assign sqrt_st[0]    = sq_in;

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		vmu_sqrt_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sqrt_valid[k]),
			.up_item  (sqrt_item[k]),
			.up_sq    (sqrt_st[k]),
			.dn_valid (sqrt_valid[k+1]),
			.dn_item  (sqrt_item[k+1]),
			.dn_sq    (sqrt_st[k+1])
		);
	end

	// Divider setup: length result, magnitudes, rounding offset and the quotient range check.
	always_comb begin
		it6_d = sqrt_item[32];
		root  = sqrt_st[32].root;
		if (it6_d.op == OP_LEN) begin
			it6_d.s  = root[31] ? S32_MAX : root;
			it6_d.ov = root[31];
		end
		for (int i = 0; i < 3; i++) begin
			if (it6_d.op == OP_DIV) begin
				dsig[i] = {it6_d.b[i][31], it6_d.b[i]};
			end else begin
				dsig[i] = {1'b0, root};
			end
			mn[i]        = it6_d.a[i][31] ? 32'(-it6_d.a[i]) : it6_d.a[i];
			mdm[i]       = dsig[i][32] ? 32'(-dsig[i]) : dsig[i][31:0];
			nfull[i]     = {1'b0, mn[i], {FRAC_BITS{1'b0}}} + NW'(mdm[i][31:1]);
			hi[i]        = nfull[i][NW-1:32];
			dv_d[i].md   = mdm[i];
			dv_d[i].rem  = 32'(hi[i]);
			dv_d[i].nlo  = nfull[i][31:0];
			dv_d[i].q    = '0;
			dv_d[i].neg  = it6_d.a[i][31] ^ dsig[i][32];
			dv_d[i].dz   = mdm[i] == '0;
			dv_d[i].big  = 64'(hi[i]) >= 64'(mdm[i]);
			dv_d[i].npos = !it6_d.a[i][31] && (it6_d.a[i] != '0);
			dv_d[i].nneg = it6_d.a[i][31];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s6 <= it6_d;
			dv_s6 <= dv_d;
		end
	end

	assign div_valid[0] = v_s6;
	assign div_item[0]  = it_s6;
	assign div_ln[0]    = dv_s6;

	for (genvar k = 0; k < 32; k++) begin : g_div
		vmu_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (div_valid[k]),
			.up_item  (div_item[k]),
			.up_ln    (div_ln[k]),
			.dn_valid (div_valid[k+1]),
			.dn_item  (div_item[k+1]),
			.dn_ln    (div_ln[k+1])
		);
	end

	// Output stage: sign, saturation and divide-by-zero results.
	always_comb begin
		it7_d = div_item[32];
		if (it7_d.op == OP_DIV || it7_d.op == OP_UNIT) begin
			for (int i = 0; i < 3; i++) begin
				if (div_ln[32][i].dz) begin
					it7_d.dz   = 1'b1;
					it7_d.r[i] = div_ln[32][i].npos ? S32_MAX :
						(div_ln[32][i].nneg ? S32_MIN : '0);
				end else if (div_ln[32][i].big) begin
					it7_d.ov   = 1'b1;
					it7_d.r[i] = div_ln[32][i].neg ? S32_MIN : S32_MAX;
				end else if (div_ln[32][i].neg) begin
					if (div_ln[32][i].q > S32_MIN) begin
						it7_d.ov   = 1'b1;
						it7_d.r[i] = S32_MIN;
					end else begin
						it7_d.r[i] = 32'(-div_ln[32][i].q);
					end
				end else if (div_ln[32][i].q[31]) begin
					it7_d.ov   = 1'b1;
					it7_d.r[i] = S32_MAX;
				end else begin
					it7_d.r[i] = div_ln[32][i].q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s7 <= it7_d;
		end
	end

	assign rsp_valid  = v_s7;
	assign r_x        = it_s7.r[0];
	assign r_y        = it_s7.r[1];
	assign r_z        = it_s7.r[2];
	assign scalar_out = it_s7.s;
	assign overflow   = it_s7.ov;
	assign div_zero   = it_s7.dz;

	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_zero |-> (it_s7.op == OP_DIV || it_s7.op == OP_UNIT))
		else $error("divide-by-zero flag on an operation without division");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (it_s7.op > OP_CROSS) |->
			(it_s7.r == '0 && it_s7.s == '0 && !overflow && !div_zero))
		else $error("unused operation code gave a nonzero result");

	a_scalar_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (it_s7.op == OP_DOT || it_s7.op == OP_LSQ || it_s7.op == OP_LEN)
			|-> it_s7.r == '0)
		else $error("scalar operation gave a nonzero vector");
endmodule
`default_nettype wire
